### hw/rtl/stf_pkg.sv
`timescale 1ns / 1ps

package stf_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_POINTS = 64;
  localparam int SUM_W      = COORD_BITS + 7;
  localparam int SQ_W       = 2 * COORD_BITS + 8;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PROD_W     = 2 * COORD_BITS;
  // Multiplier operand of the shift-and-add unit: the count or a coordinate sum.
  localparam int SHORT_W    = SUM_W;
  // Denominator and the two slope numerators.
  localparam int LONG_W     = SQ_W + CNT_W + 2;
  // Accumulator of the shift-and-add unit, wide enough for the shift numerators.
  localparam int ACC_W      = SUM_W + LONG_W + 2;
  localparam int FRAC_OUT   = 16;
  localparam int FRAC_IN    = 4;
  localparam int SHIFT_C    = FRAC_OUT - FRAC_IN;
  localparam int NUM_W      = ACC_W + SHIFT_C;
  localparam int DEN_W      = LONG_W + CNT_W;
  localparam int COEF_W     = 32;
  localparam int BIT_W      = $clog2(SHORT_W);
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int UOP_W      = 4;
  localparam int UOP_DEN    = 2;
  localparam int UOP_LAST   = 15;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_SINGULAR = 2'd2
  } stf_status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_CHECK, S_MLOAD, S_MRUN, S_MEND, S_DLOAD, S_DRUN, S_DEND, S_DONE
  } stf_state_e;

  typedef enum logic [2:0] { SH_N, SH_SX, SH_SY, SH_SU, SH_SV } stf_short_e;

  typedef enum logic [2:0] {
    LG_Q, LG_P, LG_R, LG_SX, LG_SY, LG_DEN, LG_NA, LG_NB
  } stf_long_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_DEN, DST_NA, DST_NB, DST_ND, DST_CN, DST_DN
  } stf_dest_e;

  typedef struct packed {
    stf_short_e short_sel;
    stf_long_e  long_sel;
    logic       sub;
    logic       first;
    stf_dest_e  dest;
  } stf_uop_t;

  typedef struct packed {
    logic              load_item;
    logic              acc_en;
    logic [1:0]        acc_phase;
    logic              mac_load;
    logic              mac_step;
    logic              mac_top;
    logic              mac_store;
    logic [UOP_W-1:0]  uop;
    logic              div_load;
    logic              div_step;
    logic              div_end;
    logic [1:0]        div_sel;
    logic              emit;
    stf_status_e       status;
  } stf_cmd_t;

  typedef struct packed {
    logic last;
    logic count_lt2;
    logic den_zero;
  } stf_stat_t;

  // Sequence of multiply-accumulate steps that builds the normal-equation terms.
  function automatic stf_uop_t stf_uop(input logic [UOP_W-1:0] idx);
    stf_uop_t u;
    u = '{SH_N, LG_Q, 1'b0, 1'b1, DST_NONE};
    case (idx)
      4'd0:  u = '{SH_N,  LG_Q,   1'b0, 1'b1, DST_NONE};
      4'd1:  u = '{SH_SX, LG_SX,  1'b1, 1'b0, DST_NONE};
      4'd2:  u = '{SH_SY, LG_SY,  1'b1, 1'b0, DST_DEN};
      4'd3:  u = '{SH_N,  LG_P,   1'b0, 1'b1, DST_NONE};
      4'd4:  u = '{SH_SU, LG_SX,  1'b1, 1'b0, DST_NONE};
      4'd5:  u = '{SH_SV, LG_SY,  1'b1, 1'b0, DST_NA};
      4'd6:  u = '{SH_N,  LG_R,   1'b0, 1'b1, DST_NONE};
      4'd7:  u = '{SH_SV, LG_SX,  1'b1, 1'b0, DST_NONE};
      4'd8:  u = '{SH_SU, LG_SY,  1'b0, 1'b0, DST_NB};
      4'd9:  u = '{SH_N,  LG_DEN, 1'b0, 1'b1, DST_ND};
      4'd10: u = '{SH_SU, LG_DEN, 1'b0, 1'b1, DST_NONE};
      4'd11: u = '{SH_SX, LG_NA,  1'b1, 1'b0, DST_NONE};
      4'd12: u = '{SH_SY, LG_NB,  1'b0, 1'b0, DST_CN};
      4'd13: u = '{SH_SV, LG_DEN, 1'b0, 1'b1, DST_NONE};
      4'd14: u = '{SH_SX, LG_NB,  1'b1, 1'b0, DST_NONE};
      4'd15: u = '{SH_SY, LG_NA,  1'b1, 1'b0, DST_DN};
      default: u = '{SH_N, LG_Q, 1'b0, 1'b1, DST_NONE};
    endcase
    return u;
  endfunction

endpackage

### hw/rtl/stf_ctrl.sv
`timescale 1ns / 1ps

module stf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  stf_pkg::stf_stat_t stat_i,
  output stf_pkg::stf_cmd_t  cmd_o
);

  stf_pkg::stf_state_e  state_q, state_d;
  logic [1:0]                   phase_q, phase_d;
  logic [stf_pkg::UOP_W-1:0]    uop_q, uop_d;
  logic [stf_pkg::BIT_W-1:0]    bit_q, bit_d;
  logic [stf_pkg::STEP_W-1:0]   step_q, step_d;
  logic [1:0]                   dsel_q, dsel_d;
  stf_pkg::stf_status_e         status_q, status_d;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    uop_d    = uop_q;
    bit_d    = bit_q;
    step_d   = step_q;
    dsel_d   = dsel_q;
    status_d = status_q;
    case (state_q)
      stf_pkg::S_IDLE: begin
        phase_d = 2'd0;
        if (start_i) state_d = stf_pkg::S_ACC;
      end
      stf_pkg::S_ACC: begin
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd3) state_d = stat_i.last ? stf_pkg::S_CHECK : stf_pkg::S_IDLE;
      end
      stf_pkg::S_CHECK: begin
        uop_d = '0;
        if (stat_i.count_lt2) begin
          status_d = stf_pkg::ST_FEW;
          state_d  = stf_pkg::S_DONE;
        end else begin
          state_d = stf_pkg::S_MLOAD;
        end
      end
      stf_pkg::S_MLOAD: begin
        bit_d   = '0;
        state_d = stf_pkg::S_MRUN;
      end
      stf_pkg::S_MRUN: begin
        bit_d = bit_q + 1'b1;
        if (bit_q == stf_pkg::BIT_W'(stf_pkg::SHORT_W - 1)) state_d = stf_pkg::S_MEND;
      end
      stf_pkg::S_MEND: begin
        if (uop_q == stf_pkg::UOP_W'(stf_pkg::UOP_DEN) && stat_i.den_zero) begin
          status_d = stf_pkg::ST_SINGULAR;
          state_d  = stf_pkg::S_DONE;
        end else if (uop_q == stf_pkg::UOP_W'(stf_pkg::UOP_LAST)) begin
          dsel_d  = 2'd0;
          state_d = stf_pkg::S_DLOAD;
        end else begin
          uop_d   = uop_q + 1'b1;
          state_d = stf_pkg::S_MLOAD;
        end
      end
      stf_pkg::S_DLOAD: begin
        step_d  = '0;
        state_d = stf_pkg::S_DRUN;
      end
      stf_pkg::S_DRUN: begin
        step_d = step_q + 1'b1;
        if (step_q == stf_pkg::STEP_W'(stf_pkg::NUM_W - 1)) state_d = stf_pkg::S_DEND;
      end
      stf_pkg::S_DEND: begin
        if (dsel_q == 2'd3) begin
          status_d = stf_pkg::ST_OK;
          state_d  = stf_pkg::S_DONE;
        end else begin
          dsel_d  = dsel_q + 2'd1;
          state_d = stf_pkg::S_DLOAD;
        end
      end
      stf_pkg::S_DONE: begin
        state_d = stf_pkg::S_IDLE;
      end
      default: state_d = stf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.acc_phase = phase_q;
    cmd_o.uop       = uop_q;
    cmd_o.div_sel   = dsel_q;
    cmd_o.status    = status_q;
    cmd_o.mac_top   = (bit_q == stf_pkg::BIT_W'(stf_pkg::SHORT_W - 1));
    busy_o          = (state_q != stf_pkg::S_IDLE);
    case (state_q)
      stf_pkg::S_IDLE:  cmd_o.load_item = start_i;
      stf_pkg::S_ACC:   cmd_o.acc_en    = 1'b1;
      stf_pkg::S_MLOAD: cmd_o.mac_load  = 1'b1;
      stf_pkg::S_MRUN:  cmd_o.mac_step  = 1'b1;
      stf_pkg::S_MEND:  cmd_o.mac_store = 1'b1;
      stf_pkg::S_DLOAD: cmd_o.div_load  = 1'b1;
      stf_pkg::S_DRUN:  cmd_o.div_step  = 1'b1;
      stf_pkg::S_DEND:  cmd_o.div_end   = 1'b1;
      stf_pkg::S_DONE:  cmd_o.emit      = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stf_pkg::S_IDLE;
      phase_q  <= '0;
      uop_q    <= '0;
      bit_q    <= '0;
      step_q   <= '0;
      dsel_q   <= '0;
      status_q <= stf_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      uop_q    <= uop_d;
      bit_q    <= bit_d;
      step_q   <= step_d;
      dsel_q   <= dsel_d;
      status_q <= status_d;
    end
  end

endmodule

### hw/rtl/stf_dp.sv
`timescale 1ns / 1ps

module stf_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  stf_pkg::stf_cmd_t                     cmd_i,
  output stf_pkg::stf_stat_t                    stat_o,
  input  logic                                  rotation_enable_we_i,
  input  logic                                  rotation_enable_i,
  input  logic signed [stf_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [stf_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic signed [stf_pkg::COORD_BITS-1:0] target_x_i,
  input  logic signed [stf_pkg::COORD_BITS-1:0] target_y_i,
  input  logic                                  point_valid_i,
  input  logic                                  target_valid_i,
  input  logic                                  last_point_i,
  output logic                                  result_valid_o,
  output logic signed [stf_pkg::COEF_W-1:0]     scale_cos_o,
  output logic signed [stf_pkg::COEF_W-1:0]     scale_sin_o,
  output logic signed [stf_pkg::COEF_W-1:0]     shift_x_o,
  output logic signed [stf_pkg::COEF_W-1:0]     shift_y_o,
  output logic [1:0]                            fit_status_o
);

  localparam int CW = stf_pkg::COORD_BITS;
  localparam int AW = stf_pkg::ACC_W;
  localparam int NW = stf_pkg::NUM_W;
  localparam int DW = stf_pkg::DEN_W;
  localparam int LW = stf_pkg::LONG_W;
  localparam int KW = stf_pkg::COEF_W;

  logic                          rot_en_q;
  logic signed [CW-1:0]          x_q, y_q, u_q, v_q;
  logic                          usable_q, rot_q, last_q;
  logic [stf_pkg::CNT_W-1:0]     cnt_q;
  logic signed [stf_pkg::SUM_W-1:0] sx_q, sy_q, su_q, sv_q;
  logic signed [stf_pkg::SQ_W-1:0]  sq_q, dot_q, crs_q;
  logic signed [stf_pkg::PROD_W-1:0] p0_q, p1_q;
  logic signed [CW-1:0]          m0_b, m1_b;
  logic signed [stf_pkg::SQ_W-1:0] pe0, pe1;

  logic signed [AW-1:0]          acc_q, a_sh_q, long_op, term;
  logic signed [stf_pkg::SHORT_W-1:0] b_sh_q, short_op;
  stf_pkg::stf_uop_t             uop;
  logic                          neg_term;
  logic signed [LW-1:0]          den_q, na_q, nb_q;
  logic signed [DW-1:0]          nd_q;
  logic signed [AW-1:0]          cn_q, dn_q;

  logic signed [NW-1:0]          num_s;
  logic signed [DW-1:0]          den_s;
  logic [NW-1:0]                 num_abs, q_sh_q;
  logic [DW-1:0]                 den_abs, dd_q, rem_q;
  logic [DW:0]                   rem2;
  logic                          qbit, dneg_q;
  logic signed [KW-1:0]          sat;
  logic signed [KW-1:0]          ca_q, cb_q, cc_q, cd_q;
  logic                          valid_q;
  logic signed [KW-1:0]          oa_q, ob_q, oc_q, od_q;
  logic [1:0]                    ost_q;

  assign stat_o.last      = last_q;
  assign stat_o.count_lt2 = (cnt_q < stf_pkg::CNT_W'(2));
  assign stat_o.den_zero  = (acc_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rot_en_q <= 1'b1;
    else if (rotation_enable_we_i) rot_en_q <= rotation_enable_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      u_q      <= target_x_i;
      v_q      <= target_y_i;
      rot_q    <= rot_en_q;
      last_q   <= last_point_i;
      usable_q <= point_valid_i && (!rot_en_q || target_valid_i) &&
                  (cnt_q < stf_pkg::CNT_W'(stf_pkg::MAX_POINTS));
    end
  end

  // Two products per cycle: squares, then dot terms, then cross terms.
  always_comb begin
    case (cmd_i.acc_phase)
      2'd0:    begin m0_b = x_q; m1_b = y_q; end
      2'd1:    begin m0_b = u_q; m1_b = v_q; end
      default: begin m0_b = v_q; m1_b = u_q; end
    endcase
  end

  assign pe0 = stf_pkg::SQ_W'(p0_q);
  assign pe1 = stf_pkg::SQ_W'(p1_q);

  always_ff @(posedge clk_i) begin
    p0_q <= x_q * m0_b;
    p1_q <= y_q * m1_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      su_q  <= '0;
      sv_q  <= '0;
      sq_q  <= '0;
      dot_q <= '0;
      crs_q <= '0;
    end else if (cmd_i.emit) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      su_q  <= '0;
      sv_q  <= '0;
      sq_q  <= '0;
      dot_q <= '0;
      crs_q <= '0;
    end else if (cmd_i.acc_en && usable_q) begin
      case (cmd_i.acc_phase)
        2'd0: begin
          cnt_q <= cnt_q + 1'b1;
          sx_q  <= sx_q + stf_pkg::SUM_W'(x_q);
          sy_q  <= sy_q + stf_pkg::SUM_W'(y_q);
          su_q  <= su_q + stf_pkg::SUM_W'(u_q);
          sv_q  <= sv_q + stf_pkg::SUM_W'(v_q);
        end
        2'd1:    sq_q  <= sq_q + pe0 + pe1;
        2'd2:    dot_q <= dot_q + pe0 + pe1;
        default: crs_q <= crs_q + pe0 - pe1;
      endcase
    end
  end

  // Shift-and-add multiplier: one bit of the short operand per cycle.
  assign uop = stf_pkg::stf_uop(cmd_i.uop);

  always_comb begin
    case (uop.short_sel)
      stf_pkg::SH_SX: short_op = sx_q;
      stf_pkg::SH_SY: short_op = sy_q;
      stf_pkg::SH_SU: short_op = su_q;
      stf_pkg::SH_SV: short_op = sv_q;
      default:        short_op = stf_pkg::SHORT_W'(cnt_q);
    endcase
    case (uop.long_sel)
      stf_pkg::LG_P:   long_op = AW'(dot_q);
      stf_pkg::LG_R:   long_op = AW'(crs_q);
      stf_pkg::LG_SX:  long_op = AW'(sx_q);
      stf_pkg::LG_SY:  long_op = AW'(sy_q);
      stf_pkg::LG_DEN: long_op = AW'(den_q);
      stf_pkg::LG_NA:  long_op = AW'(na_q);
      stf_pkg::LG_NB:  long_op = AW'(nb_q);
      default:         long_op = AW'(sq_q);
    endcase
  end

  // The top bit of a two's complement multiplier carries negative weight.
  assign term     = b_sh_q[0] ? a_sh_q : '0;
  assign neg_term = uop.sub ^ cmd_i.mac_top;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_load) begin
      a_sh_q <= long_op;
      b_sh_q <= short_op;
      if (uop.first) acc_q <= '0;
    end else if (cmd_i.mac_step) begin
      acc_q  <= neg_term ? acc_q - term : acc_q + term;
      a_sh_q <= a_sh_q <<< 1;
      b_sh_q <= b_sh_q >>> 1;
    end
    if (cmd_i.mac_store) begin
      case (uop.dest)
        stf_pkg::DST_DEN: den_q <= acc_q[LW-1:0];
        stf_pkg::DST_NA:  na_q  <= acc_q[LW-1:0];
        stf_pkg::DST_NB:  nb_q  <= rot_q ? acc_q[LW-1:0] : '0;
        stf_pkg::DST_ND:  nd_q  <= acc_q[DW-1:0];
        stf_pkg::DST_CN:  cn_q  <= acc_q;
        stf_pkg::DST_DN:  dn_q  <= acc_q;
        default: ;
      endcase
    end
  end

  // Restoring divider on magnitudes; half the divisor is added first to round.
  always_comb begin
    case (cmd_i.div_sel)
      2'd0: begin
        num_s = {(NW - stf_pkg::FRAC_OUT)'(na_q), stf_pkg::FRAC_OUT'(0)};
        den_s = DW'(den_q);
      end
      2'd1: begin
        num_s = {(NW - stf_pkg::FRAC_OUT)'(nb_q), stf_pkg::FRAC_OUT'(0)};
        den_s = DW'(den_q);
      end
      2'd2: begin
        num_s = {cn_q, stf_pkg::SHIFT_C'(0)};
        den_s = nd_q;
      end
      default: begin
        num_s = {dn_q, stf_pkg::SHIFT_C'(0)};
        den_s = nd_q;
      end
    endcase
    num_abs = num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
    den_abs = den_s[DW-1] ? DW'(-den_s) : DW'(den_s);
  end

  assign rem2 = {rem_q, q_sh_q[NW-1]};
  assign qbit = (rem2 >= {1'b0, dd_q});

  always_comb begin
    if (dneg_q) begin
      if ((|q_sh_q[NW-1:KW]) || (q_sh_q[KW-1] && (|q_sh_q[KW-2:0])))
        sat = {1'b1, (KW - 1)'(0)};
      else
        sat = -$signed(q_sh_q[KW-1:0]);
    end else begin
      if (|q_sh_q[NW-1:KW-1]) sat = {1'b0, {(KW - 1){1'b1}}};
      else sat = $signed(q_sh_q[KW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dneg_q <= num_s[NW-1] ^ den_s[DW-1];
      dd_q   <= den_abs;
      rem_q  <= '0;
      q_sh_q <= num_abs + NW'(den_abs >> 1);
    end else if (cmd_i.div_step) begin
      rem_q  <= qbit ? DW'(rem2 - {1'b0, dd_q}) : rem2[DW-1:0];
      q_sh_q <= {q_sh_q[NW-2:0], qbit};
    end
    if (cmd_i.div_end) begin
      case (cmd_i.div_sel)
        2'd0:    ca_q <= sat;
        2'd1:    cb_q <= sat;
        2'd2:    cc_q <= sat;
        default: cd_q <= sat;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ost_q <= cmd_i.status;
      if (cmd_i.status == stf_pkg::ST_OK) begin
        oa_q <= ca_q;
        ob_q <= cb_q;
        oc_q <= cc_q;
        od_q <= cd_q;
      end else begin
        oa_q <= '0;
        ob_q <= '0;
        oc_q <= '0;
        od_q <= '0;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign scale_cos_o    = oa_q;
  assign scale_sin_o    = ob_q;
  assign shift_x_o      = oc_q;
  assign shift_y_o      = od_q;
  assign fit_status_o   = ost_q;

endmodule

### hw/rtl/similarity_transform_fit_top.sv
`timescale 1ns / 1ps
// Least-squares similarity transform fit over a set of point pairs.
// Input: a pair (pos_x/pos_y, target_x/target_y, flags) is taken at a clock
// edge where start_i is high and busy_o is low. Each pair occupies the block
// while the accumulator adds it in (two multipliers, one sum a cycle), and
// the next pair is taken only once busy_o is low again.
// A pair with last_point_i set ends the set: the normal-equation terms are
// built by a shift-and-add multiplier, sixteen products (load, one bit step
// for each of the 23 multiplier bits, store), then four restoring divisions
// (load, one step for each of the 86 quotient bits, store) produce a, b, c
// and d. With too few pairs the result follows the count check, and for a
// singular system it follows the denominator product.
// Output: result_valid_o is high for exactly one cycle with the coefficients
// and fit_status_o; the receiver cannot stall, so it must take the
// transaction in that cycle. The sums clear after every result. Reset: rst_ni
// clears the sums and sets rotation on. Configuration: rotation_enable_we_i
// writes rotation_enable_i; the user must do so while idle (not enforced).
module similarity_transform_fit_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [stf_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [stf_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic signed [stf_pkg::COORD_BITS-1:0] target_x_i,
  input  logic signed [stf_pkg::COORD_BITS-1:0] target_y_i,
  input  logic                                  point_valid_i,
  input  logic                                  target_valid_i,
  input  logic                                  last_point_i,
  input  logic                                  rotation_enable_we_i,
  input  logic                                  rotation_enable_i,
  output logic                                  result_valid_o,
  output logic signed [stf_pkg::COEF_W-1:0]     scale_cos_o,
  output logic signed [stf_pkg::COEF_W-1:0]     scale_sin_o,
  output logic signed [stf_pkg::COEF_W-1:0]     shift_x_o,
  output logic signed [stf_pkg::COEF_W-1:0]     shift_y_o,
  output logic [1:0]                            fit_status_o
);

  stf_pkg::stf_cmd_t  cmd;
  stf_pkg::stf_stat_t stat;

  stf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  stf_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .rotation_enable_we_i (rotation_enable_we_i),
    .rotation_enable_i    (rotation_enable_i),
    .pos_x_i              (pos_x_i),
    .pos_y_i              (pos_y_i),
    .target_x_i           (target_x_i),
    .target_y_i           (target_y_i),
    .point_valid_i        (point_valid_i),
    .target_valid_i       (target_valid_i),
    .last_point_i         (last_point_i),
    .result_valid_o       (result_valid_o),
    .scale_cos_o          (scale_cos_o),
    .scale_sin_o          (scale_sin_o),
    .shift_x_o            (shift_x_o),
    .shift_y_o            (shift_y_o),
    .fit_status_o         (fit_status_o)
  );

endmodule

### hw/rtl/stf_checker.sv
`timescale 1ns / 1ps

module stf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              result_valid_o,
  input logic [stf_pkg::COEF_W-1:0]        scale_cos_o,
  input logic [stf_pkg::COEF_W-1:0]        scale_sin_o,
  input logic [stf_pkg::COEF_W-1:0]        shift_x_o,
  input logic [stf_pkg::COEF_W-1:0]        shift_y_o,
  input logic [1:0]                        fit_status_o
);

  // An accepted transaction always keeps the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("block not busy after an accepted pair");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // A result is issued only as the block finishes its work.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o) && !busy_o)
    else $error("result without a preceding busy period");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && fit_status_o != stf_pkg::ST_OK |->
      scale_cos_o == '0 && scale_sin_o == '0 && shift_x_o == '0 && shift_y_o == '0)
    else $error("coefficients not zero on an error status");

endmodule

bind similarity_transform_fit_top stf_checker u_stf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .scale_cos_o    (scale_cos_o),
  .scale_sin_o    (scale_sin_o),
  .shift_x_o      (shift_x_o),
  .shift_y_o      (shift_y_o),
  .fit_status_o   (fit_status_o)
);

### tb/sv/tb_similarity_transform_fit_top.sv
`timescale 1ns / 1ps

module tb_similarity_transform_fit_top;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 40;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [31:0]          scale_cos;
    logic [31:0]          scale_sin;
    logic [31:0]          shift_x;
    logic [31:0]          shift_y;
    stf_pkg::stf_status_e status;
  } fit_result_t;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  start_i;
  logic                                  busy_o;
  logic signed [stf_pkg::COORD_BITS-1:0] pos_x_i;
  logic signed [stf_pkg::COORD_BITS-1:0] pos_y_i;
  logic signed [stf_pkg::COORD_BITS-1:0] target_x_i;
  logic signed [stf_pkg::COORD_BITS-1:0] target_y_i;
  logic                                  point_valid_i;
  logic                                  target_valid_i;
  logic                                  last_point_i;
  logic                                  rotation_enable_we_i;
  logic                                  rotation_enable_i;
  logic                                  result_valid_o;
  logic signed [stf_pkg::COEF_W-1:0]     scale_cos_o;
  logic signed [stf_pkg::COEF_W-1:0]     scale_sin_o;
  logic signed [stf_pkg::COEF_W-1:0]     shift_x_o;
  logic signed [stf_pkg::COEF_W-1:0]     shift_y_o;
  logic [1:0]                            fit_status_o;

  similarity_transform_fit_top u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .pos_x_i              (pos_x_i),
    .pos_y_i              (pos_y_i),
    .target_x_i           (target_x_i),
    .target_y_i           (target_y_i),
    .point_valid_i        (point_valid_i),
    .target_valid_i       (target_valid_i),
    .last_point_i         (last_point_i),
    .rotation_enable_we_i (rotation_enable_we_i),
    .rotation_enable_i    (rotation_enable_i),
    .result_valid_o       (result_valid_o),
    .scale_cos_o          (scale_cos_o),
    .scale_sin_o          (scale_sin_o),
    .shift_x_o            (shift_x_o),
    .shift_y_o            (shift_y_o),
    .fit_status_o         (fit_status_o)
  );

  // Shadow copy of the block's accumulators and register.
  bit                                rot_on;
  int                                n_pairs;
  logic signed [stf_pkg::SUM_W-1:0]  acc_x, acc_y, acc_u, acc_v;
  logic signed [stf_pkg::SQ_W-1:0]   acc_sq, acc_dot, acc_cross;

  fit_result_t fits_pending[$];
  int          mismatches;
  int          idle_pct;
  int          stall_count;
  int          items_sent;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] round_div(input wide_t num, input wide_t den);
    logic [255:0] mag_n, mag_d, quo;
    bit           neg;
    neg   = num[255] ^ den[255];
    mag_n = num[255] ? -num : num;
    mag_d = den[255] ? -den : den;
    quo   = (mag_n + (mag_d >> 1)) / mag_d;
    if (neg) begin
      if (quo > 256'h8000_0000) return 32'h8000_0000;
      return -quo[31:0];
    end
    if (quo > 256'h7fff_ffff) return 32'h7fff_ffff;
    return quo[31:0];
  endfunction

  function automatic void clear_sums();
    n_pairs = 0;
    acc_x = '0; acc_y = '0; acc_u = '0; acc_v = '0;
    acc_sq = '0; acc_dot = '0; acc_cross = '0;
  endfunction

  // Updates the shadow sums for one pair and queues the fit when the set ends.
  function automatic void predict_pair(input logic signed [15:0] px, py, tx, ty,
                                       input bit pv, tv, last);
    logic signed [63:0] x, y, u, v;
    wide_t       nn, sx, sy, su, sv, den, na, nb, cn, dn;
    fit_result_t res;
    x = px; y = py; u = tx; v = ty;
    if (pv && (!rot_on || tv) && n_pairs < stf_pkg::MAX_POINTS) begin
      n_pairs++;
      acc_x = acc_x + stf_pkg::SUM_W'(x);
      acc_y = acc_y + stf_pkg::SUM_W'(y);
      acc_u = acc_u + stf_pkg::SUM_W'(u);
      acc_v = acc_v + stf_pkg::SUM_W'(v);
      acc_sq = acc_sq + stf_pkg::SQ_W'(x * x + y * y);
      acc_dot = acc_dot + stf_pkg::SQ_W'(x * u + y * v);
      acc_cross = acc_cross + stf_pkg::SQ_W'(x * v - y * u);
    end
    if (!last) return;
    res = '{32'd0, 32'd0, 32'd0, 32'd0, stf_pkg::ST_OK};
    if (n_pairs < 2) begin
      res.status = stf_pkg::ST_FEW;
    end else begin
      nn = wide_t'(n_pairs);
      sx = wide_t'(acc_x); sy = wide_t'(acc_y);
      su = wide_t'(acc_u); sv = wide_t'(acc_v);
      den = nn * wide_t'(acc_sq) - sx * sx - sy * sy;
      if (den == 0) begin
        res.status = stf_pkg::ST_SINGULAR;
      end else begin
        na = nn * wide_t'(acc_dot) - sx * su - sy * sv;
        nb = rot_on ? nn * wide_t'(acc_cross) - sx * sv + sy * su : wide_t'(0);
        cn = su * den - sx * na + sy * nb;
        dn = sv * den - sx * nb - sy * na;
        res.scale_cos = round_div(na <<< 16, den);
        res.scale_sin = round_div(nb <<< 16, den);
        res.shift_x   = round_div(cn <<< 12, nn * den);
        res.shift_y   = round_div(dn <<< 12, nn * den);
      end
    end
    fits_pending.push_back(res);
    clear_sums();
  endfunction

  // Result checker; the block cannot be stalled, so every strobe is a transaction.
  always @(posedge clk_i) begin
    fit_result_t want;
    if (rst_ni && result_valid_o) begin
      if (fits_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
      end else begin
        want = fits_pending.pop_front();
        if (scale_cos_o !== want.scale_cos || scale_sin_o !== want.scale_sin ||
            shift_x_o !== want.shift_x || shift_y_o !== want.shift_y ||
            fit_status_o !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch at %0t: exp a=%h b=%h c=%h d=%h st=%0d",
                      " got a=%h b=%h c=%h d=%h st=%0d"},
                     $realtime, want.scale_cos, want.scale_sin, want.shift_x,
                     want.shift_y, want.status, scale_cos_o, scale_sin_o,
                     shift_x_o, shift_y_o, fit_status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Sends one pair; start stays high after the transaction so back-to-back pairs
  // need only one assignment per edge.
  task automatic send_pair(input logic signed [15:0] px, py, tx, ty,
                           input bit pv, tv, last);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    pos_x_i        <= px;
    pos_y_i        <= py;
    target_x_i     <= tx;
    target_y_i     <= ty;
    point_valid_i  <= pv;
    target_valid_i <= tv;
    last_point_i   <= last;
    do @(posedge clk_i); while (busy_o);
    predict_pair(px, py, tx, ty, pv, tv, last);
    items_sent++;
  endtask

  // Stops sending and waits until the block has drained every expected result.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (fits_pending.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_rotation(input bit on);
    drain();
    rotation_enable_we_i <= 1'b1;
    rotation_enable_i    <= on;
    @(posedge clk_i);
    rotation_enable_we_i <= 1'b0;
    rot_on = on;
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(5))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(255) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  // One set of pairs: mostly transformed copies of the positions, some noise.
  task automatic send_set(input int pairs);
    logic signed [15:0] px, py, tx, ty, dx, dy;
    bit                 swap, noisy, pv, tv;
    dx = 16'($urandom_range(2000) - 1000);
    dy = 16'($urandom_range(2000) - 1000);
    swap = $urandom_range(1) == 1;
    noisy = $urandom_range(4) == 0;
    for (int i = 0; i < pairs; i++) begin
      px = ($urandom_range(3) == 0) ? rand_coord() : 16'($urandom_range(8000) - 4000);
      py = ($urandom_range(3) == 0) ? rand_coord() : 16'($urandom_range(8000) - 4000);
      if (noisy) begin
        tx = rand_coord(); ty = rand_coord();
      end else begin
        tx = (swap ? -py : px) + dx + $signed(4'($urandom));
        ty = (swap ? px : py) + dy + $signed(4'($urandom));
      end
      pv = $urandom_range(9) != 0;
      tv = $urandom_range(9) != 0;
      send_pair(px, py, tx, ty, pv, tv, i == pairs - 1);
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    // A lone pair, and a set whose pairs are all unusable, give too few pairs.
    send_pair(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 1'b1, 1'b1);
    send_pair(16'sd100, 16'sd5, 16'sd3, 16'sd7, 1'b0, 1'b1, 1'b0);
    send_pair(16'sd100, 16'sd5, 16'sd3, 16'sd7, 1'b1, 1'b0, 1'b1);
    // Identical points make the system singular.
    send_pair(16'sd16, 16'sd32, 16'sd1, 16'sd2, 1'b1, 1'b1, 1'b0);
    send_pair(16'sd16, 16'sd32, 16'sd5, 16'sd9, 1'b1, 1'b1, 1'b0);
    send_pair(16'sd16, 16'sd32, 16'sd7, 16'sd3, 1'b1, 1'b1, 1'b1);
    // Extremes of every coordinate, including a usable last pair.
    send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b0);
    send_pair(16'sh0000, 16'shffff, 16'sh0001, 16'sh8000, 1'b1, 1'b1, 1'b1);
    // Pure rotation by a quarter turn with a shift.
    send_pair(16'sd160, 16'sd0, 16'sd10, 16'sd180, 1'b1, 1'b1, 1'b0);
    send_pair(16'sd0, 16'sd160, -16'sd150, 16'sd20, 1'b1, 1'b1, 1'b0);
    send_pair(-16'sd160, 16'sd0, 16'sd10, -16'sd140, 1'b1, 1'b1, 1'b1);
    // More pairs than the block keeps: the surplus is dropped.
    send_set(stf_pkg::MAX_POINTS + 6);
    drain();
  endtask

  task automatic test_rotation_off();
    set_rotation(1'b0);
    idle_pct = 12;
    // Target flags are ignored here, so an invalid target still counts.
    send_pair(16'sd100, 16'sd50, 16'sd210, 16'sd90, 1'b1, 1'b0, 1'b0);
    send_pair(-16'sd80, 16'sd40, -16'sd150, 16'sd70, 1'b1, 1'b0, 1'b1);
    for (int s = 0; s < 20; s++) send_set($urandom_range(2, 10));
    set_rotation(1'b1);
  endtask

  task automatic test_random(input int pct, input int target_items);
    int first_item;
    first_item = items_sent;
    idle_pct = pct;
    while (items_sent - first_item < target_items) begin
      if ($urandom_range(19) == 0)
        send_set($urandom_range(stf_pkg::MAX_POINTS - 4, stf_pkg::MAX_POINTS + 6));
      else send_set($urandom_range(1, 10));
      if ($urandom_range(29) == 0) set_rotation($urandom_range(1) == 1);
    end
    drain();
  endtask

  initial begin
    rst_ni               = 1'b0;
    start_i              = 1'b0;
    pos_x_i              = '0;
    pos_y_i              = '0;
    target_x_i           = '0;
    target_y_i           = '0;
    point_valid_i        = 1'b0;
    target_valid_i       = 1'b0;
    last_point_i         = 1'b0;
    rotation_enable_we_i = 1'b0;
    rotation_enable_i    = 1'b1;
    mismatches           = 0;
    items_sent           = 0;
    stall_count          = 0;
    rot_on               = 1'b1;
    clear_sums();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rotation_off();
    test_random(0, 500);
    test_random(72, 500);
    test_random(72, 400);
    test_random(12, 500);
    set_rotation(1'b1);
    drain();

    if (mismatches == 0 && fits_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/stf_pkg.sv
hw/rtl/stf_ctrl.sv
hw/rtl/stf_dp.sv
hw/rtl/similarity_transform_fit_top.sv
hw/rtl/stf_checker.sv
tb/sv/tb_similarity_transform_fit_top.sv
